// ===== sv/crrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_pkg
// Shared types, codes and saturating fixed-point helpers for the cubic root
// refinement step.
// ----------------------------------------------------------------------------
package crrs_pkg;

  localparam int FRAC_BITS = 32;
  localparam int WORD_W    = 64;
  localparam int TOL_W     = 63;

  localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_MIN = 64'h8000_0000_0000_0000;
  localparam logic [62:0] TOL_RESET = 63'd42950;

  // configuration register indexes
  localparam logic [2:0] REG_COEF_X3     = 3'd0;
  localparam logic [2:0] REG_COEF_X2     = 3'd1;
  localparam logic [2:0] REG_COEF_X1     = 3'd2;
  localparam logic [2:0] REG_COEF_X0     = 3'd3;
  localparam logic [2:0] REG_FIXED_SLOPE = 3'd4;
  localparam logic [2:0] REG_TOLERANCE   = 3'd5;

  // step modes
  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_HALF   = 3'd1;
  localparam logic [2:0] MODE_NEWTON = 3'd2;
  localparam logic [2:0] MODE_SLOPE  = 3'd3;
  localparam logic [2:0] MODE_SECANT = 3'd4;

  // micro-operations
  localparam logic [3:0] OP_LOAD        = 4'd0;
  localparam logic [3:0] OP_SETOLD      = 4'd1;
  localparam logic [3:0] OP_MAC         = 4'd2;
  localparam logic [3:0] OP_SAVE_DV     = 4'd3;
  localparam logic [3:0] OP_SLOPE_DV    = 4'd4;
  localparam logic [3:0] OP_SAVE_NM     = 4'd5;
  localparam logic [3:0] OP_SAVE_FP     = 4'd6;
  localparam logic [3:0] OP_SAVE_FX     = 4'd7;
  localparam logic [3:0] OP_SET_SECANT  = 4'd8;
  localparam logic [3:0] OP_DIV         = 4'd9;
  localparam logic [3:0] OP_UPD_HALF    = 4'd10;
  localparam logic [3:0] OP_UPD_NEWTON  = 4'd11;
  localparam logic [3:0] OP_UPD_SECANT  = 4'd12;
  localparam logic [3:0] OP_JMP         = 4'd13;
  localparam logic [3:0] OP_STEP        = 4'd14;
  localparam logic [3:0] OP_FINAL       = 4'd15;

  // multiplier coefficient operand
  localparam logic [1:0] A_COEF3 = 2'd0;
  localparam logic [1:0] A_C3X3  = 2'd1;
  localparam logic [1:0] A_ACC   = 2'd2;
  localparam logic [1:0] A_QT    = 2'd3;

  // multiplier point operand
  localparam logic [1:0] V_OLD  = 2'd0;
  localparam logic [1:0] V_PREV = 2'd1;
  localparam logic [1:0] V_CUR  = 2'd2;
  localparam logic [1:0] V_FX   = 2'd3;

  // addend after a multiply
  localparam logic [2:0] C_C2   = 3'd0;
  localparam logic [2:0] C_C2X2 = 3'd1;
  localparam logic [2:0] C_C1   = 3'd2;
  localparam logic [2:0] C_C0   = 3'd3;
  localparam logic [2:0] C_ZERO = 3'd4;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] a_sel;
    logic [1:0] v_sel;
    logic [2:0] c_sel;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic issue;
    logic accept;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic dv_zero;
  } status_t;

  function automatic logic [63:0] magnitude(input logic [63:0] s);
    return s[63] ? (~s + 64'd1) : s;
  endfunction

  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (neg) begin
      return m[63] ? SAT_MIN : (~m + 64'd1);
    end
    return m[63] ? SAT_MAX : m;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SAT_MIN : SAT_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SAT_MIN : SAT_MAX;
    end
    return s[63:0];
  endfunction

endpackage

// ===== sv/crrs_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_mul
// Saturating fixed-point multiplier, four 32x32 partial products accumulated
// in turn, then scaling and saturation.
// ----------------------------------------------------------------------------
module crrs_mul #(
  parameter int FRAC_BITS = crrs_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] result
);

  logic [63:0]  xm;
  logic [63:0]  ym;
  logic         neg;
  logic [127:0] prod;
  logic [1:0]   cnt;
  logic         busy;
  logic         fin;
  logic [31:0]  xs;
  logic [31:0]  ys;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  sat_val;

  always_comb begin
    xs = cnt[0] ? xm[63:32] : xm[31:0];
    ys = cnt[1] ? ym[63:32] : ym[31:0];
    pp = 64'(xs) * 64'(ys);
    unique case (cnt)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    if ((prod >> (64 + FRAC_BITS)) != 128'd0) begin
      sat_val = neg ? crrs_pkg::SAT_MIN : crrs_pkg::SAT_MAX;
    end else begin
      sat_val = crrs_pkg::from_mag(neg, prod[FRAC_BITS +: 64]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= 2'd0;
      end else if (busy) begin
        if (!fin) begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            fin <= 1'b1;
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xm   <= crrs_pkg::magnitude(op_a);
      ym   <= crrs_pkg::magnitude(op_b);
      neg  <= op_a[63] ^ op_b[63];
      prod <= 128'd0;
    end else if (busy && !fin) begin
      prod <= prod + pp_sh;
    end else if (busy && fin) begin
      result <= sat_val;
    end
  end

endmodule

// ===== sv/crrs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_div
// Saturating fixed-point divider, restoring, one quotient bit a cycle over
// the 128-bit scaled dividend.
// ----------------------------------------------------------------------------
module crrs_div #(
  parameter int FRAC_BITS = crrs_pkg::FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] result
);

  logic [127:0] num;
  logic [63:0]  rem;
  logic [63:0]  dm;
  logic         neg;
  logic [6:0]   cnt;
  logic         busy;
  logic         fin;
  logic [64:0]  rsh;
  logic         qbit;
  logic [64:0]  rdiff;
  logic [63:0]  sat_val;

  always_comb begin
    rsh   = {rem, num[127]};
    rdiff = rsh - {1'b0, dm};
    qbit  = (rsh >= {1'b0, dm});
    if (num[127:64] != 64'd0) begin
      sat_val = neg ? crrs_pkg::SAT_MIN : crrs_pkg::SAT_MAX;
    end else begin
      sat_val = crrs_pkg::from_mag(neg, num[63:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!fin) begin
          cnt <= cnt + 7'd1;
          if (cnt == 7'd127) begin
            fin <= 1'b1;
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= 128'(crrs_pkg::magnitude(op_a)) << FRAC_BITS;
      dm  <= crrs_pkg::magnitude(op_b);
      neg <= op_a[63] ^ op_b[63];
      rem <= 64'd0;
    end else if (busy && !fin) begin
      num <= {num[126:0], qbit};
      rem <= qbit ? rdiff[63:0] : rsh[63:0];
    end else if (busy && fin) begin
      result <= sat_val;
    end
  end

endmodule

// ===== sv/crrs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_dpath
// Datapath: configuration registers, iteration state, working registers,
// shared multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
module crrs_dpath #(
  parameter int FRAC_BITS = crrs_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  crrs_pkg::cmd_t      cmd,
  output crrs_pkg::status_t   status,
  input  logic [2:0]          in_mode,
  input  logic [63:0]         in_start_x,
  input  logic [63:0]         in_start_previous,
  input  logic [62:0]         in_start_half_width,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output logic [63:0]         x_now,
  output logic [63:0]         f_at_x,
  output logic [62:0]         step_length,
  output logic                converged,
  output logic                divide_error
);

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  logic [63:0] coef3, coef2, coef1, coef0, slope;
  logic [62:0] tol;

  logic [2:0]  mode;
  logic [63:0] sx, sp;
  logic [62:0] shw;

  logic [63:0] cur_x, prev_x, old_x;
  logic [62:0] hw;
  logic [63:0] acc, fx, fp, dv, nm, qt;
  logic [62:0] step;
  logic        err;
  logic [2:0]  c_lat;

  logic [63:0] c3x3, c2x2;
  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_start, mul_done;
  logic        div_start, div_done;
  logic [63:0] div_res;
  logic [63:0] addend;
  logic [64:0] dstep;
  logic [64:0] dstep_mag;
  logic [62:0] step_val;
  logic [62:0] hw_half;
  logic        conv_val;

  always_comb begin
    c3x3 = crrs_pkg::sat_add(crrs_pkg::sat_add(coef3, coef3), coef3);
    c2x2 = crrs_pkg::sat_add(coef2, coef2);
    unique case (cmd.uop.a_sel)
      crrs_pkg::A_COEF3: mul_a = coef3;
      crrs_pkg::A_C3X3:  mul_a = c3x3;
      crrs_pkg::A_ACC:   mul_a = acc;
      default:           mul_a = qt;
    endcase
    unique case (cmd.uop.v_sel)
      crrs_pkg::V_OLD:  mul_b = old_x;
      crrs_pkg::V_PREV: mul_b = prev_x;
      crrs_pkg::V_CUR:  mul_b = cur_x;
      default:          mul_b = fx;
    endcase
    unique case (c_lat)
      crrs_pkg::C_C2:   addend = coef2;
      crrs_pkg::C_C2X2: addend = c2x2;
      crrs_pkg::C_C1:   addend = coef1;
      crrs_pkg::C_C0:   addend = coef0;
      default:          addend = 64'd0;
    endcase
    mul_start = cmd.issue && (cmd.uop.op == crrs_pkg::OP_MAC);
    div_start = cmd.issue && (cmd.uop.op == crrs_pkg::OP_DIV) && (dv != 64'd0);
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.dv_zero  = (dv == 64'd0);
    dstep     = {cur_x[63], cur_x} - {old_x[63], old_x};
    dstep_mag = dstep[64] ? (~dstep + 65'd1) : dstep;
    step_val  = (dstep_mag[64] || dstep_mag[63]) ? {63{1'b1}} : dstep_mag[62:0];
    hw_half   = hw >> 1;
    if (mode == crrs_pkg::MODE_HALF) begin
      conv_val = ({1'b0, step} <= {tol, 1'b0});
    end else begin
      conv_val = (crrs_pkg::magnitude(acc) <= {1'b0, tol});
    end
  end

  crrs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  crrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .op_a   (nm),
    .op_b   (dv),
    .done   (div_done),
    .result (div_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef3 <= ONE;
      coef2 <= 64'd0;
      coef1 <= 64'd0;
      coef0 <= 64'd0;
      slope <= ONE;
      tol   <= crrs_pkg::TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crrs_pkg::REG_COEF_X3:     coef3 <= cfg_data;
        crrs_pkg::REG_COEF_X2:     coef2 <= cfg_data;
        crrs_pkg::REG_COEF_X1:     coef1 <= cfg_data;
        crrs_pkg::REG_COEF_X0:     coef0 <= cfg_data;
        crrs_pkg::REG_FIXED_SLOPE: slope <= cfg_data;
        crrs_pkg::REG_TOLERANCE:   tol   <= cfg_data[62:0];
        default: ;
      endcase
    end
  end

  // iteration state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x  <= 64'd0;
      prev_x <= 64'd0;
      hw     <= 63'd0;
    end else if (cmd.issue) begin
      unique case (cmd.uop.op)
        crrs_pkg::OP_LOAD: begin
          cur_x  <= sx;
          prev_x <= sp;
          hw     <= shw;
        end
        crrs_pkg::OP_UPD_HALF: begin
          hw <= hw_half;
          if (!acc[63] && (acc != 64'd0)) begin
            cur_x <= crrs_pkg::sat_sub(old_x, {1'b0, hw_half});
          end else if (acc[63]) begin
            cur_x <= crrs_pkg::sat_add(old_x, {1'b0, hw_half});
          end
        end
        crrs_pkg::OP_UPD_NEWTON: cur_x <= crrs_pkg::sat_sub(old_x, qt);
        crrs_pkg::OP_UPD_SECANT: begin
          cur_x  <= crrs_pkg::sat_sub(old_x, acc);
          prev_x <= old_x;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode <= in_mode;
      sx   <= in_start_x;
      sp   <= in_start_previous;
      shw  <= in_start_half_width;
    end
    if (mul_start) begin
      c_lat <= cmd.uop.c_sel;
    end
    if (mul_done) begin
      acc <= crrs_pkg::sat_add(mul_res, addend);
    end
    if (div_done) begin
      qt <= div_res;
    end
    if (cmd.issue) begin
      unique case (cmd.uop.op)
        crrs_pkg::OP_LOAD: begin
          old_x <= sx;
          err   <= 1'b0;
        end
        crrs_pkg::OP_SETOLD: begin
          old_x <= cur_x;
          err   <= 1'b0;
        end
        crrs_pkg::OP_SAVE_DV:  dv <= acc;
        crrs_pkg::OP_SLOPE_DV: dv <= slope;
        crrs_pkg::OP_SAVE_NM:  nm <= acc;
        crrs_pkg::OP_SAVE_FP:  fp <= acc;
        crrs_pkg::OP_SAVE_FX:  fx <= acc;
        crrs_pkg::OP_SET_SECANT: begin
          dv <= crrs_pkg::sat_sub(fx, fp);
          nm <= crrs_pkg::sat_sub(old_x, prev_x);
        end
        crrs_pkg::OP_DIV: begin
          if (dv == 64'd0) begin
            err <= 1'b1;
          end
        end
        crrs_pkg::OP_STEP: step <= step_val;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      x_now        <= cur_x;
      f_at_x       <= acc;
      step_length  <= step;
      converged    <= conv_val;
      divide_error <= err;
    end
  end

endmodule

// ===== sv/crrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_ctrl
// Controller: microcode sequencer that walks the step program of each mode,
// waits on the multiplier and divider, and owns both handshakes.
// ----------------------------------------------------------------------------
module crrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [2:0]        s_mode,
  output logic              m_tvalid,
  input  logic              m_tready,
  output crrs_pkg::cmd_t    cmd,
  input  crrs_pkg::status_t status
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_ISSUE    = 2'd1;
  localparam logic [1:0] ST_WAIT_MUL = 2'd2;
  localparam logic [1:0] ST_WAIT_DIV = 2'd3;

  localparam logic [5:0] PC_FINISH = 6'd0;
  localparam logic [5:0] PC_LOAD   = 6'd5;
  localparam logic [5:0] PC_HALF   = 6'd7;
  localparam logic [5:0] PC_NEWTON = 6'd13;
  localparam logic [5:0] PC_SLOPE  = 6'd24;
  localparam logic [5:0] PC_SECANT = 6'd33;
  localparam logic [5:0] PC_OTHER  = 6'd47;

  logic [1:0] state;
  logic [5:0] pc;
  logic       slot_free;

  function automatic crrs_pkg::uop_t mk(input logic [3:0] op, input logic [1:0] a,
                                        input logic [1:0] v, input logic [2:0] c);
    crrs_pkg::uop_t u;
    u.op    = op;
    u.a_sel = a;
    u.v_sel = v;
    u.c_sel = c;
    return u;
  endfunction

  function automatic crrs_pkg::uop_t plain(input logic [3:0] op);
    return mk(op, crrs_pkg::A_COEF3, crrs_pkg::V_OLD, crrs_pkg::C_ZERO);
  endfunction

  function automatic crrs_pkg::uop_t ucode(input logic [5:0] addr);
    crrs_pkg::uop_t u;
    unique case (addr)
      // finish: step, f at the new point, result
      6'd0:  u = plain(crrs_pkg::OP_STEP);
      6'd1:  u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_COEF3, crrs_pkg::V_CUR, crrs_pkg::C_C2);
      6'd2:  u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_CUR, crrs_pkg::C_C1);
      6'd3:  u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_CUR, crrs_pkg::C_C0);
      6'd4:  u = plain(crrs_pkg::OP_FINAL);
      // load
      6'd5:  u = plain(crrs_pkg::OP_LOAD);
      // halving
      6'd7:  u = plain(crrs_pkg::OP_SETOLD);
      6'd8:  u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_COEF3, crrs_pkg::V_OLD, crrs_pkg::C_C2);
      6'd9:  u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C1);
      6'd10: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C0);
      6'd11: u = plain(crrs_pkg::OP_UPD_HALF);
      // newton
      6'd13: u = plain(crrs_pkg::OP_SETOLD);
      6'd14: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_C3X3, crrs_pkg::V_OLD, crrs_pkg::C_C2X2);
      6'd15: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C1);
      6'd16: u = plain(crrs_pkg::OP_SAVE_DV);
      6'd17: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_COEF3, crrs_pkg::V_OLD, crrs_pkg::C_C2);
      6'd18: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C1);
      6'd19: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C0);
      6'd20: u = plain(crrs_pkg::OP_SAVE_NM);
      6'd21: u = plain(crrs_pkg::OP_DIV);
      6'd22: u = plain(crrs_pkg::OP_UPD_NEWTON);
      // fixed slope
      6'd24: u = plain(crrs_pkg::OP_SETOLD);
      6'd25: u = plain(crrs_pkg::OP_SLOPE_DV);
      6'd26: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_COEF3, crrs_pkg::V_OLD, crrs_pkg::C_C2);
      6'd27: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C1);
      6'd28: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C0);
      6'd29: u = plain(crrs_pkg::OP_SAVE_NM);
      6'd30: u = plain(crrs_pkg::OP_DIV);
      6'd31: u = plain(crrs_pkg::OP_UPD_NEWTON);
      // secant
      6'd33: u = plain(crrs_pkg::OP_SETOLD);
      6'd34: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_COEF3, crrs_pkg::V_PREV, crrs_pkg::C_C2);
      6'd35: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_PREV, crrs_pkg::C_C1);
      6'd36: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_PREV, crrs_pkg::C_C0);
      6'd37: u = plain(crrs_pkg::OP_SAVE_FP);
      6'd38: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_COEF3, crrs_pkg::V_OLD, crrs_pkg::C_C2);
      6'd39: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C1);
      6'd40: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_ACC, crrs_pkg::V_OLD, crrs_pkg::C_C0);
      6'd41: u = plain(crrs_pkg::OP_SAVE_FX);
      6'd42: u = plain(crrs_pkg::OP_SET_SECANT);
      6'd43: u = plain(crrs_pkg::OP_DIV);
      6'd44: u = mk(crrs_pkg::OP_MAC, crrs_pkg::A_QT, crrs_pkg::V_FX, crrs_pkg::C_ZERO);
      6'd45: u = plain(crrs_pkg::OP_UPD_SECANT);
      // unused modes
      6'd47: u = plain(crrs_pkg::OP_SETOLD);
      default: u = plain(crrs_pkg::OP_JMP);
    endcase
    return u;
  endfunction

  function automatic logic [5:0] entry(input logic [2:0] mode);
    logic [5:0] a;
    unique case (mode)
      crrs_pkg::MODE_LOAD:   a = PC_LOAD;
      crrs_pkg::MODE_HALF:   a = PC_HALF;
      crrs_pkg::MODE_NEWTON: a = PC_NEWTON;
      crrs_pkg::MODE_SLOPE:  a = PC_SLOPE;
      crrs_pkg::MODE_SECANT: a = PC_SECANT;
      default:               a = PC_OTHER;
    endcase
    return a;
  endfunction

  always_comb begin
    slot_free    = !m_tvalid || m_tready;
    s_tready     = (state == ST_IDLE);
    cmd.uop      = ucode(pc);
    cmd.issue    = (state == ST_ISSUE);
    cmd.accept   = s_tvalid && (state == ST_IDLE);
    cmd.out_load = (state == ST_ISSUE) && (cmd.uop.op == crrs_pkg::OP_FINAL) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= PC_FINISH;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pc    <= entry(s_mode);
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          unique case (cmd.uop.op)
            crrs_pkg::OP_MAC: state <= ST_WAIT_MUL;
            crrs_pkg::OP_DIV: begin
              if (status.dv_zero) begin
                pc <= PC_FINISH;
              end else begin
                state <= ST_WAIT_DIV;
              end
            end
            crrs_pkg::OP_JMP: pc <= PC_FINISH;
            crrs_pkg::OP_FINAL: begin
              if (slot_free) begin
                state <= ST_IDLE;
              end
            end
            default: pc <= pc + 6'd1;
          endcase
        end
        ST_WAIT_MUL: begin
          if (status.mul_done) begin
            pc    <= pc + 6'd1;
            state <= ST_ISSUE;
          end
        end
        default: begin
          if (status.div_done) begin
            pc    <= pc + 6'd1;
            state <= ST_ISSUE;
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/cubic_root_refinement_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_root_refinement_step
// One refinement step toward a root of a3*x^3 + a2*x^2 + a1*x + a0 in
// saturating signed fixed point, selected by the mode on tuser.
// ----------------------------------------------------------------------------
// Each transaction runs a short microcode program on one shared multiplier,
// used for each multiply-add, and one radix-2 divider. A zero divisor skips
// the division and the rest of the update. A result held back by m_tready
// adds its wait to the item in progress. One item is worked on at a time;
// the next is accepted while the previous result still waits in the output
// register.
module cubic_root_refinement_step #(
  parameter int FRAC_BITS = crrs_pkg::FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,   // start_x, start_previous, start_half_width
  input  logic [2:0]   s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [199:0] m_tdata,   // x_now, f_at_x, step_length, converged, divide_error
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  crrs_pkg::cmd_t    cmd;
  crrs_pkg::status_t status;
  logic [63:0]       x_now;
  logic [63:0]       f_at_x;
  logic [62:0]       step_length;
  logic              converged;
  logic              divide_error;

  crrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_mode   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  crrs_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .in_mode             (s_tuser),
    .in_start_x          (s_tdata[63:0]),
    .in_start_previous   (s_tdata[127:64]),
    .in_start_half_width (s_tdata[190:128]),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .x_now               (x_now),
    .f_at_x              (f_at_x),
    .step_length         (step_length),
    .converged           (converged),
    .divide_error        (divide_error)
  );

  assign m_tdata = {7'd0, divide_error, converged, step_length, f_at_x, x_now};

endmodule
